/* rtl/sbsh_pkg.sv */
// Package for the SHA-256 byte stream hasher: widths, opcodes, round
// constants, initial hash values and the round functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbsh_pkg;

   localparam int BlockBytes = 64;
   localparam int WordCount  = 8;
   localparam int RoundCount = 64;
   localparam int ByteAddrW  = 6;
   localparam int WordAddrW  = 3;
   localparam int RoundW     = 6;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   function automatic word_type round_k(input logic [RoundW-1:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic word_type initial_h(input logic [WordAddrW-1:0] idx);
      word_type h;
      unique case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
         default: h = 32'h0;
      endcase
      return h;
   endfunction

   function automatic word_type ror(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big0(input word_type x);
      return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic word_type big1(input word_type x);
      return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

endpackage
`default_nettype wire

/* rtl/sbsh_if.sv */
// Valid/ready channel interfaces for the hasher's request and response items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sbsh_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   modport source (output valid, opcode, data_byte, input ready);
   modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface sbsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* rtl/sbsh_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sbsh_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher: byte buffer, padding,
// round sequencer and digest output. Depends on sbsh_pkg, sbsh_if, sbsh_ram.
//
//   channel  dir  fields                               handshake
//   req      in   opcode, data_byte                    req.valid/req.ready
//   rsp      out  digest_word, word_index, last_word   rsp.valid/rsp.ready
//
// Data bytes are taken while idle; every 64th byte runs a compression:
// 64 byte reads from the block RAM through its single read port, then 64
// rounds, one per cycle.
// A finish pads (up to 72 byte writes), compresses once or twice, then
// emits eight words. Reset is synchronous and restores the initial chaining
// values in a sweep over the eight words. A stalled rsp holds the word.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher
   import sbsh_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   sbsh_req_if.sink   req,
   sbsh_rsp_if.source rsp
);
   localparam int Depth = BlockBytes;
   localparam int AW = ByteAddrW;

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_PAD    = 4'd2;
   localparam logic [3:0] ST_LOAD   = 4'd3;
   localparam logic [3:0] ST_ROUND  = 4'd4;
   localparam logic [3:0] ST_HRD    = 4'd5;
   localparam logic [3:0] ST_HADD   = 4'd6;
   localparam logic [3:0] ST_OUTRD  = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [63:0]   bits_ff, bits_in, total_ff, total_in;
   logic          final_ff, final_in;   // compression is the last of a finish
   logic          padlen_ff, padlen_in; // current block carries the length
   logic [AW-1:0] pad_ff, pad_in;
   logic [6:0]    cnt_ff, cnt_in;
   word_type      v_ff [8];
   word_type      v_in [8];
   word_type      w_ff [16];
   word_type      w_in [16];
   word_type      wt;
   logic [WordAddrW-1:0] hidx_ff, hidx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_word_ff, rsp_word_in;

   logic                 b_we;
   logic [AW-1:0]        b_wa, b_ra;
   byte_type             b_wd, b_rd;
   logic                 h_we;
   logic [WordAddrW-1:0] h_wa, h_ra;
   word_type             h_wd, h_rd;

   sbsh_ram #(.Width(8), .Depth(Depth)) u_block (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   sbsh_ram #(.Width(32), .Depth(WordCount)) u_chain (
      .clock, .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));

   assign req.ready       = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.digest_word = rsp_word_ff;
   assign rsp.word_index  = hidx_ff;
   assign rsp.last_word   = (hidx_ff == 3'd7);

   logic take;
   assign take = req.valid && req.ready;

   always_comb begin
      word_type t1, t2;
      t1 = '0;
      t2 = '0;
      state_in = state_ff; fill_in = fill_ff; bits_in = bits_ff;
      total_in = total_ff; final_in = final_ff; padlen_in = padlen_ff;
      pad_in = pad_ff; cnt_in = cnt_ff; v_in = v_ff; w_in = w_ff;
      hidx_in = hidx_ff; rsp_valid_in = rsp_valid_ff; rsp_word_in = rsp_word_ff;
      b_we = 1'b0; b_wa = fill_ff; b_wd = req.data_byte; b_ra = '0;
      h_we = 1'b0; h_wa = hidx_ff; h_wd = '0; h_ra = hidx_ff;
      wt = w_ff[0];
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            h_we = 1'b1; h_wd = initial_h(hidx_ff);
            hidx_in = hidx_ff + 3'd1;
            if (hidx_ff == 3'd7) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               if (req.opcode == OP_ABSORB) begin
                  b_we = 1'b1;
                  fill_in = fill_ff + 1'b1;
                  if (fill_ff == AW'(Depth - 1)) begin
                     bits_in = bits_ff + 64'd512;
                     final_in = 1'b0; cnt_in = '0; b_ra = '0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  total_in = bits_ff + {55'd0, fill_ff, 3'd0};
                  b_we = 1'b1; b_wd = PAD_MARK;
                  pad_in = fill_ff + 1'b1;
                  padlen_in = (fill_ff < AW'(56));
                  state_in = (fill_ff == AW'(Depth - 1)) ? ST_LOAD : ST_PAD;
                  final_in = (fill_ff < AW'(56));
                  cnt_in = '0;
               end
            end
         end
         ST_PAD: begin
            b_we = 1'b1; b_wa = pad_ff; b_wd = 8'h00;
            if (padlen_ff && pad_ff >= AW'(56))
               b_wd = total_ff[8*(7 - pad_ff[2:0]) +: 8];
            pad_in = pad_ff + 1'b1;
            if (pad_ff == AW'(Depth - 1)) begin
               state_in = ST_LOAD; cnt_in = '0; pad_in = pad_ff;
            end
         end
         ST_LOAD: begin
            // cnt 0 issues the first read; its data arrives in the next cycle
            b_ra = cnt_ff[AW-1:0];
            if (cnt_ff == '0) begin
               for (int i = 0; i < 8; i++) v_in[i] = v_ff[i];
            end
            if (cnt_ff != '0) begin
               w_in[15] = {w_ff[15][23:0], b_rd};
            end
            if (cnt_ff[1:0] == 2'd1 && cnt_ff != 7'd1) begin
               for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
               w_in[15] = {24'd0, b_rd};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               cnt_in = '0; hidx_in = '0; state_in = ST_HRD;
            end
         end
         ST_HRD: begin
            // copy the chaining words into the working variables
            h_ra = hidx_ff;
            if (cnt_ff != '0) v_in[cnt_ff[2:0] - 3'd1] = h_rd;
            h_ra = cnt_ff[2:0];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd8) begin
               cnt_in = '0; state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            wt = w_ff[0];
            t1 = v_ff[7] + big1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
               + round_k(cnt_ff[5:0]) + wt;
            t2 = big0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
               ^ (v_ff[1] & v_ff[2]));
            for (int i = 7; i > 0; i--) v_in[i] = v_ff[i - 1];
            v_in[4] = v_ff[3] + t1;
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = w_ff[0] + sig0(w_ff[1]) + w_ff[9] + sig1(w_ff[14]);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in = '0; state_in = ST_HADD;
            end
            h_ra = '0;
         end
         ST_HADD: begin
            // cnt 0 reads word 0; each later cycle adds and writes back
            h_ra = cnt_ff[2:0] + 3'd1;
            if (cnt_ff == '0) h_ra = '0;
            if (cnt_ff != '0) begin
               h_we = 1'b1; h_wa = cnt_ff[2:0] - 3'd1;
               h_wd = h_rd + v_ff[cnt_ff[2:0] - 3'd1];
               h_ra = cnt_ff[2:0];
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd8) begin
               cnt_in = '0;
               if (final_ff) begin
                  hidx_in = '0; state_in = ST_OUTRD;
               end else if (fill_ff == '0 && !padlen_ff && pad_ff != '0) begin
                  // second block of a two-block finish
                  padlen_in = 1'b1; final_in = 1'b1; pad_in = '0;
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUTRD: begin
            h_ra = hidx_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            h_ra = hidx_ff;
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1; rsp_word_in = h_rd;
            end else if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               if (hidx_ff == 3'd7) begin
                  hidx_in = '0; fill_in = '0; bits_in = '0;
                  final_in = 1'b0; padlen_in = 1'b0; pad_in = '0;
                  state_in = ST_INIT;
               end else begin
                  hidx_in = hidx_ff + 3'd1; state_in = ST_OUTRD;
               end
            end
         end
         default: state_in = ST_INIT;
      endcase
      // a finish leaves fill at zero so the two-block check sees it
      if (state_ff == ST_IDLE && take && req.opcode == OP_FINISH) begin
         fill_in = '0;
         if (fill_ff == AW'(Depth - 1)) pad_in = AW'(Depth - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; fill_ff <= '0; bits_ff <= '0;
         final_ff <= 1'b0; padlen_ff <= 1'b0; pad_ff <= '0;
         cnt_ff <= '0; hidx_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; bits_ff <= bits_in;
         final_ff <= final_in; padlen_ff <= padlen_in; pad_ff <= pad_in;
         cnt_ff <= cnt_in; hidx_ff <= hidx_in; rsp_valid_ff <= rsp_valid_in;
      end
      total_ff <= total_in; v_ff <= v_in; w_ff <= w_in; rsp_word_ff <= rsp_word_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp_valid_ff) else $error("ready while a word is pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("digest word dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.ready && hidx_ff == 3'd7 |=> state_ff == ST_INIT)
      else $error("no restart after last word");
endmodule
`default_nettype wire
